[rtl/core/sotq_pkg.sv]
package sotq_pkg;

   localparam int NUM_TIMERS = 8;
   localparam int TIME_BITS  = 24;

   typedef enum logic [1:0] {
      KIND_REGISTER   = 2'd0,
      KIND_UNREGISTER = 2'd1,
      KIND_SCHEDULE   = 2'd2,
      KIND_ELAPSE     = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_DONE      = 3'd0,
      ST_NO_FREE   = 3'd1,
      ST_EXPIRED   = 3'd2,
      ST_NONE_EXP  = 3'd3,
      ST_NOT_REG   = 3'd4
   } status_type;

   localparam logic CSR_DEFERRED_MASK = 1'b0;
   localparam logic CSR_HW_MAX_SHOT   = 1'b1;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_PREP,
      FSM_SCAN,
      FSM_INSERT,
      FSM_ELAPSE,
      FSM_FINISH,
      FSM_EMIT
   } fsm_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request
      logic prep;      // decode / allocate, remove id from list
      logic scan;      // one step of insert position search
      logic insert;    // place id at found position
      logic elapse;    // one list entry of elapse walk
      logic finish;    // compute head shot
      logic pop;       // result taken from queue
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic is_sched;
      logic is_elapse;
      logic scan_done;
      logic walk_done;
      logic q_empty;
   } stat_type;

endpackage

[rtl/core/sotq_ctrl.sv]
module sotq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  sotq_pkg::stat_type stat,
   output sotq_pkg::ctrl_type ctrl
);

   sotq_pkg::fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sotq_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sotq_pkg::FSM_IDLE:   if (req_valid) state_in = sotq_pkg::FSM_PREP;
         sotq_pkg::FSM_PREP: begin
            if (stat.is_sched) state_in = sotq_pkg::FSM_SCAN;
            else if (stat.is_elapse) state_in = sotq_pkg::FSM_ELAPSE;
            else state_in = sotq_pkg::FSM_FINISH;
         end
         sotq_pkg::FSM_SCAN:   if (stat.scan_done) state_in = sotq_pkg::FSM_INSERT;
         sotq_pkg::FSM_INSERT: state_in = sotq_pkg::FSM_FINISH;
         sotq_pkg::FSM_ELAPSE: if (stat.walk_done) state_in = sotq_pkg::FSM_FINISH;
         sotq_pkg::FSM_FINISH: state_in = sotq_pkg::FSM_EMIT;
         sotq_pkg::FSM_EMIT: begin
            if (!rsp_stall && stat.q_empty) state_in = sotq_pkg::FSM_IDLE;
         end
         default: state_in = sotq_pkg::FSM_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         sotq_pkg::FSM_IDLE: begin
            req_stall = 1'b0;
            ctrl.load = req_valid;
         end
         sotq_pkg::FSM_PREP:   ctrl.prep = 1'b1;
         sotq_pkg::FSM_SCAN:   ctrl.scan = 1'b1;
         sotq_pkg::FSM_INSERT: ctrl.insert = 1'b1;
         sotq_pkg::FSM_ELAPSE: ctrl.elapse = 1'b1;
         sotq_pkg::FSM_FINISH: ctrl.finish = 1'b1;
         sotq_pkg::FSM_EMIT: begin
            rsp_valid = 1'b1;
            ctrl.pop = !rsp_stall;
         end
         default: ;
      endcase
   end

endmodule

[rtl/core/sotq_dp.sv]
module sotq_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic                     csr_index,
   input  logic [23:0]              csr_data,
   input  logic [1:0]               req_kind,
   input  logic [2:0]               req_timer_id,
   input  logic [23:0]              req_amount,
   input  sotq_pkg::ctrl_type       ctrl,
   output sotq_pkg::stat_type       stat,
   output logic [2:0]               rsp_status,
   output logic [2:0]               rsp_result_id,
   output logic                     rsp_deferred,
   output logic                     rsp_shot_armed,
   output logic [23:0]              rsp_next_shot,
   output logic                     rsp_last
);

   localparam int NUM_TIMERS = sotq_pkg::NUM_TIMERS;
   localparam int TIME_BITS  = sotq_pkg::TIME_BITS;
   localparam int IW = $clog2(NUM_TIMERS);
   localparam int CW = $clog2(NUM_TIMERS + 1);
   localparam logic [TIME_BITS-1:0] TMAX = '1;

   logic [7:0]                 dmask_ff;
   logic [23:0]                hwmax_ff;
   logic [NUM_TIMERS-1:0]      alloc_ff;
   logic [TIME_BITS-1:0]       rem_ff [NUM_TIMERS];
   logic [IW-1:0]              list_ff [NUM_TIMERS];
   logic [CW-1:0]              cnt_ff;
   logic [CW-1:0]              pos_ff;   // scan / walk index
   logic [CW-1:0]              keep_ff;
   sotq_pkg::kind_type         kind_ff;
   logic [IW-1:0]              id_ff;
   logic [TIME_BITS-1:0]       amt_ff;
   logic                       ok_ff;

   // result queue: one entry per list member at most
   logic [2:0]                 qst_ff  [NUM_TIMERS];
   logic [2:0]                 qid_ff  [NUM_TIMERS];
   logic                       qdef_ff [NUM_TIMERS];
   logic [CW-1:0]              qn_ff;
   logic [CW-1:0]              qr_ff;
   logic                       armed_ff;
   logic [23:0]                shot_ff;

   logic [TIME_BITS-1:0]       amt_c;
   logic [IW-1:0]              free_c;
   logic                       free_ok_c;
   logic                       idok_c;
   logic [IW-1:0]              cur_c;
   logic [TIME_BITS-1:0]       cur_rem_c;
   logic [23:0]                lim_c;
   logic [TIME_BITS-1:0]       head_c;
   logic                       def_c;

   always_comb begin
      if (TIME_BITS >= 24) amt_c = TIME_BITS'(req_amount);
      else if (req_amount > 24'(TMAX)) amt_c = TMAX;
      else amt_c = TIME_BITS'(req_amount);
   end

   always_comb begin
      free_c = '0;
      free_ok_c = 1'b0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!alloc_ff[i]) begin
            free_c = IW'(i);
            free_ok_c = 1'b1;
         end
      end
   end

   assign idok_c    = (32'(id_ff) < NUM_TIMERS) && alloc_ff[id_ff];
   assign cur_c     = list_ff[pos_ff[IW-1:0]];
   assign cur_rem_c = rem_ff[cur_c];
   assign def_c     = (32'(cur_c) < 8) ? dmask_ff[3'(cur_c)] : 1'b0;
   assign lim_c     = (hwmax_ff == '0) ? 24'd1 : hwmax_ff;
   assign head_c    = rem_ff[list_ff[0]];

   assign stat.is_sched  = (kind_ff == sotq_pkg::KIND_SCHEDULE) && idok_c;
   assign stat.is_elapse = (kind_ff == sotq_pkg::KIND_ELAPSE);
   assign stat.scan_done = (pos_ff >= cnt_ff) || (cur_rem_c > amt_ff);
   assign stat.walk_done = (pos_ff + 1'b1 >= cnt_ff) || (cnt_ff == '0);
   assign stat.q_empty   = (qr_ff + 1'b1 >= qn_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dmask_ff <= '0;
         hwmax_ff <= 24'hFFFFFF;
      end else if (csr_write) begin
         if (csr_index == sotq_pkg::CSR_DEFERRED_MASK) dmask_ff <= csr_data[7:0];
         else hwmax_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff <= '0;
         cnt_ff   <= '0;
         qn_ff    <= '0;
         qr_ff    <= '0;
         for (int i = 0; i < NUM_TIMERS; i++) rem_ff[i] <= '0;
      end else begin
         if (ctrl.load) begin
            kind_ff <= sotq_pkg::kind_type'(req_kind);
            id_ff   <= IW'(req_timer_id);
            amt_ff  <= amt_c;
            ok_ff   <= (32'(req_timer_id) < NUM_TIMERS);
            qn_ff   <= '0;
            qr_ff   <= '0;
            pos_ff  <= '0;
            keep_ff <= '0;
         end
         if (ctrl.prep) begin
            logic          rm;
            logic [IW-1:0] rid;
            rm  = 1'b0;
            rid = id_ff;
            qn_ff <= CW'(1);
            qid_ff[0]  <= 3'(id_ff);
            qdef_ff[0] <= 1'b0;
            qst_ff[0]  <= sotq_pkg::ST_DONE;
            unique case (kind_ff) inside
               sotq_pkg::KIND_REGISTER: begin
                  if (!free_ok_c) begin
                     qst_ff[0] <= sotq_pkg::ST_NO_FREE;
                     qid_ff[0] <= '0;
                  end else begin
                     alloc_ff[free_c] <= 1'b1;
                     rem_ff[free_c]   <= '0;
                     qid_ff[0] <= 3'(free_c);
                  end
               end
               sotq_pkg::KIND_UNREGISTER, sotq_pkg::KIND_SCHEDULE: begin
                  if (!(ok_ff && idok_c)) begin
                     qst_ff[0] <= sotq_pkg::ST_NOT_REG;
                  end else begin
                     rm = 1'b1;
                     if (kind_ff == sotq_pkg::KIND_UNREGISTER) begin
                        alloc_ff[id_ff] <= 1'b0;
                        rem_ff[id_ff]   <= '0;
                     end else begin
                        rem_ff[id_ff] <= (amt_ff == '0) ? TIME_BITS'(1) : amt_ff;
                        amt_ff <= (amt_ff == '0) ? TIME_BITS'(1) : amt_ff;
                     end
                  end
               end
               default: qn_ff <= '0;
            endcase
            // unlink id (per-entry compaction of the remaining entries in list order)
            if (rm) begin
               logic [CW-1:0] k;
               logic          hit;
               k = '0;
               hit = 1'b0;
               for (int i = 0; i < NUM_TIMERS; i++) begin
                  if (CW'(i) < cnt_ff && list_ff[i] == rid) hit = 1'b1;
               end
               for (int i = 0; i < NUM_TIMERS; i++) begin
                  if (CW'(i) < cnt_ff && list_ff[i] != rid) begin
                     list_ff[k[IW-1:0]] <= list_ff[i];
                     k = k + 1'b1;
                  end
               end
               if (hit) cnt_ff <= cnt_ff - 1'b1;
            end
         end
         if (ctrl.scan && !stat.scan_done) pos_ff <= pos_ff + 1'b1;
         if (ctrl.insert) begin
            for (int i = 1; i < NUM_TIMERS; i++) begin
               if (CW'(i) > pos_ff && CW'(i) <= cnt_ff) list_ff[i] <= list_ff[i-1];
            end
            list_ff[pos_ff[IW-1:0]] <= id_ff;
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (ctrl.elapse) begin
            if (cnt_ff != '0) begin
               if (amt_ff != '0 && cur_rem_c <= amt_ff) begin
                  rem_ff[cur_c] <= '0;
                  qst_ff[qn_ff[IW-1:0]]  <= sotq_pkg::ST_EXPIRED;
                  qid_ff[qn_ff[IW-1:0]]  <= 3'(cur_c);
                  qdef_ff[qn_ff[IW-1:0]] <= def_c;
                  qn_ff <= qn_ff + 1'b1;
               end else begin
                  rem_ff[cur_c] <= cur_rem_c - amt_ff;
                  list_ff[keep_ff[IW-1:0]] <= cur_c;
                  keep_ff <= keep_ff + 1'b1;
               end
            end
            pos_ff <= pos_ff + 1'b1;
            if (stat.walk_done) begin
               logic exp;
               exp = (cnt_ff != '0) && amt_ff != '0 && cur_rem_c <= amt_ff;
               cnt_ff <= (cnt_ff == '0) ? '0 : (keep_ff + (exp ? 1'b0 : 1'b1));
               if (qn_ff == '0 && !exp) begin
                  qst_ff[0]  <= sotq_pkg::ST_NONE_EXP;
                  qid_ff[0]  <= '0;
                  qdef_ff[0] <= 1'b0;
                  qn_ff <= CW'(1);
               end
            end
         end
         if (ctrl.finish) begin
            armed_ff <= (cnt_ff != '0);
            if (cnt_ff == '0) shot_ff <= '0;
            else if (48'(head_c) > 48'(lim_c)) shot_ff <= lim_c;
            else shot_ff <= 24'(head_c);
         end
         if (ctrl.pop) qr_ff <= qr_ff + 1'b1;
      end
   end

   assign rsp_status     = qst_ff[qr_ff[IW-1:0]];
   assign rsp_result_id  = qid_ff[qr_ff[IW-1:0]];
   assign rsp_deferred   = qdef_ff[qr_ff[IW-1:0]];
   assign rsp_shot_armed = armed_ff;
   assign rsp_next_shot  = shot_ff;
   assign rsp_last       = stat.q_empty;

endmodule

[rtl/core/sorted_oneshot_timer_queue_top.sv]
// Sorted one-shot timer queue.
// Request channel (req_valid/req_stall): kind, timer_id, amount. One request is
// taken at a time; req_stall stays high until every response of the previous
// request has been transferred.
// Response channel (rsp_valid/rsp_stall): register, unregister and schedule
// give one response; elapse gives one per expired timer in list order, or a
// single "nothing expired" response. rsp_last marks the final one.
// Sequence: prep, then for a schedule of a registered id a list scan for the
// insert position and an insert, for elapse a walk over the list one entry
// per cycle, then finish and emit. Responses then leave one per cycle while
// rsp_stall is low; while it is high the current response is held and nothing
// advances. csr_write takes deferred_mask (index 0) or hw_max_shot (index 1);
// the user must write them only when idle, as the block does not enforce it.
// Synchronous reset empties the list, frees all ids and restores the registers.
module sorted_oneshot_timer_queue_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [23:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [2:0]  req_timer_id,
   input  logic [23:0] req_amount,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_result_id,
   output logic        rsp_deferred,
   output logic        rsp_shot_armed,
   output logic [23:0] rsp_next_shot,
   output logic        rsp_last
);

   sotq_pkg::ctrl_type ctrl;
   sotq_pkg::stat_type stat;

   sotq_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .stat, .ctrl
   );

   sotq_dp u_dp (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req_kind, .req_timer_id, .req_amount, .ctrl, .stat,
      .rsp_status, .rsp_result_id, .rsp_deferred, .rsp_shot_armed,
      .rsp_next_shot, .rsp_last
   );

endmodule

[rtl/core/sotq_checker.sv]
module sotq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic        rsp_shot_armed,
   input logic [23:0] rsp_next_shot,
   input logic        rsp_last
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled response changed");

   a_shot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_shot_armed |-> rsp_next_shot == '0)
      else $error("shot without armed timer");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken back to back");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("response burst ended early");

endmodule

bind sorted_oneshot_timer_queue_top sotq_checker u_sotq_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_status, .rsp_shot_armed, .rsp_next_shot, .rsp_last
);
